// File: src/piecewise_linear_opacity_ramp_top_assert.svh
// assertion macros shared by the opacity ramp rtl
`ifndef PIECEWISE_LINEAR_OPACITY_RAMP_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_OPACITY_RAMP_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define PLOR_ASSERT_HOLDS(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequence holds in the same cycle as the trigger
`define PLOR_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the trigger
`define PLOR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/plor_pkg.sv
// types and constants shared by the opacity ramp modules
package plor_pkg;

    localparam int MAX_POINTS = 16;
    localparam int MAX_PIXELS = 4096;

    localparam int PT_IDX_W  = $clog2(MAX_POINTS);
    localparam int PT_CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PIX_IDX_W = $clog2(MAX_PIXELS);
    localparam int PIX_N_W   = $clog2(MAX_PIXELS + 1);

    localparam int COORD_W  = 17;
    localparam int GAIN_W   = 17;
    localparam int PCOUNT_W = 13;
    localparam int BYTE_W   = 8;
    localparam int POINT_W  = 2 * COORD_W;
    localparam int XQ_W     = 16;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;
    localparam int CFG_IDX_W = 1;

    // shared restoring divider
    localparam int DIV_W       = 17;
    localparam int DIV_BITS    = 16;
    localparam int DIV_CNT_W   = $clog2(DIV_BITS + 1);
    localparam int XQ_STEPS    = 16;
    localparam int ALPHA_STEPS = 8;

    typedef enum logic [S_TUSER_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_PIXEL  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPACITY_GAIN = 1'b0,
        REG_PIXEL_COUNT  = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_SCAN,
        ST_LOWER,
        ST_MUL,
        ST_SUM,
        ST_SCALE,
        ST_TRUNC,
        ST_CLAMP,
        ST_DIV_A,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     rem_init;
        logic [DIV_W-1:0]     divisor;
        logic [DIV_BITS-1:0]  bits;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

// File: src/plor_div.sv
// restoring divider, one quotient bit per cycle
module plor_div
    import plor_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     den_reg;
    logic [DIV_BITS-1:0]  bits_reg;
    logic [DIV_BITS-1:0]  quot_reg;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           fits;

    always_comb begin
        trial = {rem_reg, bits_reg[DIV_BITS-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= req.rem_init;
            den_reg  <= req.divisor;
            bits_reg <= req.bits;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            bits_reg <= {bits_reg[DIV_BITS-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_BITS-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

// File: src/piecewise_linear_opacity_ramp_top.sv
// Opacity ramp: control points in a 16-entry RAM, one item at a time. Clear and append
// words are taken in the idle state and can follow back to back. A colour pixel holds
// the input until its word is loaded into the output register: the pixel position and,
// when the alpha is neither saturated nor zero, the final alpha quotient go through one
// shared restoring divider at one bit per cycle (16 bits, then 8), and the segment
// search reads the point RAM one entry per cycle. A finished word waits in the output
// register while the next item is taken. The point RAM has no reset and needs no
// clearing pass; only entries written since the last clear are read.
`include "piecewise_linear_opacity_ramp_top_assert.svh"

module piecewise_linear_opacity_ramp_top
    import plor_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // point_x[16:0], point_y[33:17], red_in[41:34], green_in[49:42], blue_in[57:50]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
    output logic [M_TDATA_W-1:0] m_tdata,
    // last_pixel
    output logic                 m_tlast,
    // status[0]
    output logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_data
);

    localparam int PROD_W = 2 * (COORD_W + 1);
    localparam int SUM_W  = PROD_W + 1;
    localparam int NUM_W  = PROD_W - 1;
    localparam int P1_W   = NUM_W + GAIN_W;
    localparam int P255_W = P1_W + BYTE_W;
    localparam int T_W    = P255_W - 32;

    // control state
    state_t                state_reg, state_next;
    logic [GAIN_W-1:0]     gain_reg;
    logic [PCOUNT_W-1:0]   pcount_reg;
    logic [PT_CNT_W-1:0]   total_reg, total_next;
    logic [PIX_IDX_W-1:0]  pix_reg, pix_next;
    logic [PT_IDX_W-1:0]   seg_reg, seg_next;
    logic                  m_valid_reg;

    // point ram
    logic [POINT_W-1:0]    pts_mem [MAX_POINTS];
    logic [POINT_W-1:0]    rd_data_reg;
    logic                  rd_en;
    logic [PT_IDX_W-1:0]   rd_addr;
    logic                  wr_en;

    // per-pixel datapath
    logic [PIX_IDX_W-1:0]  i_reg;
    logic                  last_reg;
    logic                  status_reg;
    logic [BYTE_W-1:0]     red_reg, green_reg, blue_reg;
    logic [XQ_W-1:0]       xq_reg;
    logic [COORD_W-1:0]    y0_reg, y1_reg;
    logic signed [COORD_W:0] w_reg, d_reg, dy_reg;
    logic signed [PROD_W-1:0] prod_a_reg, prod_b_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [COORD_W-1:0]    wabs_reg;
    logic                  nonpos_reg;
    logic [P1_W-1:0]       p1_reg;
    logic [T_W-1:0]        t_reg;
    logic [BYTE_W-1:0]     alpha_reg, alpha_next;
    logic                  alpha_load;
    logic [M_TDATA_W-1:0]  m_data_reg;
    logic                  m_last_reg;
    logic                  m_user_reg;

    div_req_t              div_req;
    div_rsp_t              div_rsp;

    op_t                   op;
    logic                  accept;
    logic                  out_free;
    logic                  out_load;
    logic                  advance;
    logic                  sat;
    logic [31:0]           pc_wide;
    logic [PIX_N_W-1:0]    n_eff;
    logic [PIX_N_W-1:0]    n_last_full;
    logic [PIX_IDX_W-1:0]  n_last;
    logic [PIX_IDX_W-1:0]  i_eff;
    logic [PT_CNT_W-1:0]   seg_p1, seg_p2;
    logic [PT_IDX_W-1:0]   seg_eff;
    logic [COORD_W-1:0]    rd_x, rd_y;
    logic signed [SUM_W-1:0] sum_w, snum;
    logic signed [COORD_W:0] wneg;
    logic [P255_W-1:0]     p255;

    plor_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign op        = op_t'(s_tuser);
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign rd_x      = rd_data_reg[COORD_W-1:0];
    assign rd_y      = rd_data_reg[POINT_W-1:COORD_W];

    // ramp length and the clamped pixel index
    always_comb begin
        pc_wide = 32'(pcount_reg);
        if (pc_wide == 32'd0) begin
            n_eff = PIX_N_W'(1);
        end else if (pc_wide > 32'(MAX_PIXELS)) begin
            n_eff = PIX_N_W'(MAX_PIXELS);
        end else begin
            n_eff = pc_wide[PIX_N_W-1:0];
        end
        n_last_full = n_eff - PIX_N_W'(1);
        n_last      = n_last_full[PIX_IDX_W-1:0];
        i_eff       = (pix_reg > n_last) ? n_last : pix_reg;
    end

    // interpolation arithmetic
    always_comb begin
        sum_w = {prod_a_reg[PROD_W-1], prod_a_reg} + {prod_b_reg[PROD_W-1], prod_b_reg};
        snum  = w_reg[COORD_W] ? -sum_w : sum_w;
        wneg  = -w_reg;
        p255  = {p1_reg, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, p1_reg};
        sat   = t_reg >= T_W'({wabs_reg, {BYTE_W{1'b0}}});
    end

    always_comb begin
        state_next = state_reg;
        total_next = total_reg;
        pix_next   = pix_reg;
        seg_next   = seg_reg;
        rd_en      = 1'b0;
        rd_addr    = seg_reg;
        wr_en      = 1'b0;
        out_load   = 1'b0;
        alpha_load = 1'b0;
        alpha_next = '0;
        advance    = 1'b0;
        div_req    = '0;
        seg_p1     = PT_CNT_W'(seg_reg) + PT_CNT_W'(1);
        seg_p2     = PT_CNT_W'(seg_reg) + PT_CNT_W'(2);
        seg_eff    = (seg_p1 >= total_reg) ? '0 : seg_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_CLEAR: begin
                            total_next = '0;
                            pix_next   = '0;
                            seg_next   = '0;
                        end
                        OP_APPEND: begin
                            if (total_reg < PT_CNT_W'(MAX_POINTS)) begin
                                wr_en      = 1'b1;
                                total_next = total_reg + PT_CNT_W'(1);
                            end
                        end
                        OP_PIXEL: begin
                            // x = floor(i * 2^16 / n): remainder starts at i, zeros shift in
                            div_req.start    = 1'b1;
                            div_req.rem_init = DIV_W'(i_eff);
                            div_req.divisor  = DIV_W'(n_eff);
                            div_req.bits     = '0;
                            div_req.steps    = DIV_CNT_W'(XQ_STEPS);
                            state_next       = ST_DIV_X;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV_X: begin
                if (div_rsp.done) begin
                    if (status_reg) begin
                        alpha_load = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        seg_next   = seg_eff;
                        rd_en      = 1'b1;
                        rd_addr    = seg_eff + PT_IDX_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // read data holds the upper point of the current segment
                if (seg_p2 < total_reg && {1'b0, xq_reg} > rd_x) begin
                    advance  = 1'b1;
                    seg_next = seg_p1[PT_IDX_W-1:0];
                    rd_en    = 1'b1;
                    rd_addr  = seg_p2[PT_IDX_W-1:0];
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = seg_reg;
                    state_next = ST_LOWER;
                end
            end
            ST_LOWER: state_next = ST_MUL;
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_SCALE;
            ST_SCALE: begin
                if (nonpos_reg) begin
                    alpha_load = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_TRUNC;
                end
            end
            ST_TRUNC: state_next = ST_CLAMP;
            ST_CLAMP: begin
                if (sat) begin
                    alpha_load = 1'b1;
                    alpha_next = '1;
                    state_next = ST_OUT;
                end else begin
                    // quotient is below 256, so only the low byte of t is left to divide
                    div_req.start    = 1'b1;
                    div_req.rem_init = t_reg[DIV_W+BYTE_W-1:BYTE_W];
                    div_req.divisor  = wabs_reg;
                    div_req.bits     = {t_reg[BYTE_W-1:0], {(DIV_BITS-BYTE_W){1'b0}}};
                    div_req.steps    = DIV_CNT_W'(ALPHA_STEPS);
                    state_next       = ST_DIV_A;
                end
            end
            ST_DIV_A: begin
                if (div_rsp.done) begin
                    alpha_load = 1'b1;
                    alpha_next = div_rsp.quotient[BYTE_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (last_reg) begin
                        pix_next = '0;
                        seg_next = '0;
                    end else begin
                        pix_next = i_reg + PIX_IDX_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            pix_reg     <= '0;
            seg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            pix_reg   <= pix_next;
            seg_reg   <= seg_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= GAIN_W'(65536);
            pcount_reg <= PCOUNT_W'(256);
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_OPACITY_GAIN: gain_reg   <= cfg_data;
                REG_PIXEL_COUNT:  pcount_reg <= cfg_data[PCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pts_mem[total_reg[PT_IDX_W-1:0]] <= {s_tdata[33:17], s_tdata[16:0]};
        end
        if (rd_en) begin
            rd_data_reg <= pts_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && op == OP_PIXEL) begin
            i_reg      <= i_eff;
            last_reg   <= (i_eff == n_last);
            status_reg <= (total_reg < PT_CNT_W'(2));
            red_reg    <= s_tdata[41:34];
            green_reg  <= s_tdata[49:42];
            blue_reg   <= s_tdata[57:50];
        end
        if (state_reg == ST_DIV_X && div_rsp.done) begin
            xq_reg <= div_rsp.quotient[XQ_W-1:0];
        end
        if (state_reg == ST_SCAN && !advance) begin
            y1_reg <= rd_y;
            // keep x1 in w until the lower point arrives
            w_reg  <= $signed({1'b0, rd_x});
        end
        if (state_reg == ST_LOWER) begin
            y0_reg <= rd_y;
            w_reg  <= w_reg - $signed({1'b0, rd_x});
            d_reg  <= $signed({2'b00, xq_reg}) - $signed({1'b0, rd_x});
            dy_reg <= $signed({1'b0, y1_reg}) - $signed({1'b0, rd_y});
        end
        if (state_reg == ST_MUL) begin
            prod_a_reg <= PROD_W'($signed({1'b0, y0_reg})) * PROD_W'(w_reg);
            prod_b_reg <= PROD_W'(d_reg) * PROD_W'(dy_reg);
        end
        if (state_reg == ST_SUM) begin
            if (w_reg == '0) begin
                // zero-width segment takes the upper point's y over a unit width
                num_reg    <= NUM_W'(y1_reg);
                wabs_reg   <= COORD_W'(1);
                nonpos_reg <= 1'b0;
            end else begin
                num_reg    <= snum[NUM_W-1:0];
                wabs_reg   <= w_reg[COORD_W] ? wneg[COORD_W-1:0] : w_reg[COORD_W-1:0];
                nonpos_reg <= snum[SUM_W-1] || (snum == '0);
            end
        end
        if (state_reg == ST_SCALE) begin
            p1_reg <= P1_W'(num_reg) * P1_W'(gain_reg);
        end
        if (state_reg == ST_TRUNC) begin
            t_reg <= p255[P255_W-1:32];
        end
        if (alpha_load) begin
            alpha_reg <= alpha_next;
        end
        if (out_load) begin
            m_data_reg <= {alpha_reg, blue_reg, green_reg, red_reg};
            m_last_reg <= last_reg;
            m_user_reg <= status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    `PLOR_ASSERT_HOLDS(a_total_bound, total_reg <= PT_CNT_W'(MAX_POINTS), "point count overflow")
    `PLOR_ASSERT_SAME(a_scan_in_table, state_reg == ST_SCAN, seg_p1 < total_reg, "segment past table")
    `PLOR_ASSERT_NEXT(a_result_issued, out_load, m_tvalid && state_reg == ST_IDLE, "result lost")

endmodule

// File: test/piecewise_linear_opacity_ramp_top_tb.sv
// self-checking testbench for the piecewise-linear opacity ramp
module piecewise_linear_opacity_ramp_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plor_pkg::*;

    localparam logic [S_TUSER_W-1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_TARGET   = 1020;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int Q16_ONE       = 65536;

    typedef struct {
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit [7:0] alpha;
        bit       last;
        bit       status;
    } pixel_word_t;

    // predicts each pixel word from the point table and the two registers
    class opacity_ramp_checker;
        bit [COORD_W-1:0]  point_x [MAX_POINTS];
        bit [COORD_W-1:0]  point_y [MAX_POINTS];
        int unsigned       points_held;
        int unsigned       pixel_pos;
        int unsigned       segment;
        bit [GAIN_W-1:0]   gain;
        bit [PCOUNT_W-1:0] ramp_length;
        pixel_word_t       pending_pixels[$];
        int                errors;

        function new();
            points_held = 0;
            pixel_pos   = 0;
            segment     = 0;
            gain        = 17'd65536;
            ramp_length = 13'd256;
            errors      = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [GAIN_W-1:0] value);
            if (idx == REG_OPACITY_GAIN) begin
                gain = value;
            end else begin
                ramp_length = value[PCOUNT_W-1:0];
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        // line through the segment's two points, scaled by gain and 255
        function bit [7:0] interpolate_alpha(longint xq, int unsigned lo);
            longint          x0, y0, x1, y1, w, num;
            longint unsigned q;
            x0 = point_x[lo];
            y0 = point_y[lo];
            x1 = point_x[lo + 1];
            y1 = point_y[lo + 1];
            w  = x1 - x0;
            if (w == 0) begin
                q = ($unsigned(y1) * gain * 64'd255) >> 32;
            end else begin
                num = y0 * w + (xq - x0) * (y1 - y0);
                if (w < 0) begin
                    w   = -w;
                    num = -num;
                end
                if (num <= 0) return 8'd0;
                q = ($unsigned(num) * gain * 64'd255) / ($unsigned(w) << 32);
            end
            return (q > 255) ? 8'd255 : q[7:0];
        endfunction

        function pixel_word_t shade_pixel(logic [S_TDATA_W-1:0] data);
            longint unsigned n, i, xq;
            pixel_word_t     w;
            n = ramp_length;
            if (n < 1) n = 1;
            if (n > MAX_PIXELS) n = MAX_PIXELS;
            i = pixel_pos;
            if (i > n - 1) i = n - 1;
            w.last   = (i == n - 1);
            xq       = (i << 16) / n;
            w.alpha  = 8'd0;
            w.status = 1'b0;
            if (points_held < 2) begin
                w.status = 1'b1;
            end else begin
                if (segment + 1 >= points_held) segment = 0;
                while (segment + 2 < points_held && longint'(xq) > longint'(point_x[segment + 1]))
                    segment++;
                w.alpha = interpolate_alpha(longint'(xq), segment);
            end
            if (w.last) begin
                pixel_pos = 0;
                segment   = 0;
            end else begin
                pixel_pos = i + 1;
            end
            w.red   = data[41:34];
            w.green = data[49:42];
            w.blue  = data[57:50];
            return w;
        endfunction

        function void note_input(logic [S_TUSER_W-1:0] op, logic [S_TDATA_W-1:0] data);
            case (op)
                OP_CLEAR: begin
                    points_held = 0;
                    pixel_pos   = 0;
                    segment     = 0;
                end
                OP_APPEND: begin
                    if (points_held < MAX_POINTS) begin
                        point_x[points_held] = data[16:0];
                        point_y[points_held] = data[33:17];
                        points_held++;
                    end
                end
                OP_PIXEL: pending_pixels.insert(pending_pixels.size(), shade_pixel(data));
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic last, logic status);
            pixel_word_t want;
            if (pending_pixels.size() == 0) begin
                $error("output word with no pixel outstanding: tdata %h", data);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            compare_field("red_out", want.red, data[7:0]);
            compare_field("green_out", want.green, data[15:8]);
            compare_field("blue_out", want.blue, data[23:16]);
            compare_field("alpha_out", want.alpha, data[31:24]);
            compare_field("last_pixel", {7'd0, want.last}, {7'd0, last});
            compare_field("status", {7'd0, want.status}, {7'd0, status});
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0]    cfg_data;

    opacity_ramp_checker sb = new();
    int items_sent   = 0;
    bit calm         = 1'b0;
    bit hold_off_req = 1'b0;

    piecewise_linear_opacity_ramp_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser[0]);
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_word(logic [16:0] x, logic [16:0] y,
                                                       logic [7:0] r, logic [7:0] g,
                                                       logic [7:0] b);
        return {6'd0, b, g, r, y, x};
    endfunction

    function automatic logic [S_TDATA_W-1:0] noise_word();
        return pack_word($urandom_range(0, 131071), $urandom_range(0, 131071),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255));
    endfunction

    task automatic send_word(input logic [S_TUSER_W-1:0] op, input logic [S_TDATA_W-1:0] data);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        if (op != OP_UNUSED) items_sent++;
    endtask

    // waits for every pixel word, then lets a trailing clear or append settle
    task automatic wait_idle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic [GAIN_W-1:0] gain, input logic [GAIN_W-1:0] count);
        cfg_valid <= 1'b1;
        cfg_index <= REG_OPACITY_GAIN;
        cfg_data  <= gain;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(REG_OPACITY_GAIN, gain);
        cfg_index <= REG_PIXEL_COUNT;
        cfg_data  <= count;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(REG_PIXEL_COUNT, count);
        cfg_valid <= 1'b0;
    endtask

    // clear, ascending points from 0 to 1.0, then a run of pixels
    task automatic send_ramp();
        int          k;
        int unsigned x;
        int unsigned stride;
        k      = $urandom_range(2, MAX_POINTS);
        stride = 2 * Q16_ONE / (k - 1);
        x      = 0;
        send_word(OP_CLEAR, noise_word());
        for (int p = 0; p < k; p++) begin
            if (p == k - 1) begin
                x = Q16_ONE;
            end else if (p > 0 && $urandom_range(0, 7) != 0) begin
                x = x + $urandom_range(1, stride);
                if (x > Q16_ONE) x = Q16_ONE;
            end
            send_word(OP_APPEND, pack_word(x, $urandom_range(0, Q16_ONE), $urandom_range(0, 255),
                                           $urandom_range(0, 255), $urandom_range(0, 255)));
        end
        // extra points past the end, dropped once the table is full
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 4))
                send_word(OP_APPEND, pack_word(Q16_ONE, $urandom_range(0, Q16_ONE), 0, 0, 0));
        end
        repeat ($urandom_range(1, 48)) send_word(OP_PIXEL, noise_word());
    endtask

    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        #2000000;
        $display("piecewise_linear_opacity_ramp_top verification failed");
        $finish;
    end

    initial begin
        logic [GAIN_W-1:0] new_gain;
        logic [GAIN_W-1:0] new_count;
        bit                hold_done;
        hold_done = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_CLEAR;
        cfg_valid <= 1'b0;
        cfg_index <= REG_OPACITY_GAIN;
        cfg_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset registers: no points, then a single point
        send_word(OP_PIXEL, pack_word(0, 0, 0, 0, 0));
        send_word(OP_UNUSED, noise_word());
        send_word(OP_APPEND, pack_word(0, Q16_ONE, 255, 255, 255));
        send_word(OP_PIXEL, pack_word(17'h1FFFF, 17'h1FFFF, 255, 255, 255));

        // gain above 1.0, zero-width first segment saturating
        wait_idle();
        configure(17'h1FFFF, 3);
        send_word(OP_CLEAR, pack_word(0, 0, 0, 0, 0));
        send_word(OP_APPEND, pack_word(0, 0, 0, 0, 0));
        send_word(OP_APPEND, pack_word(0, Q16_ONE, 0, 0, 0));
        send_word(OP_APPEND, pack_word(Q16_ONE, 0, 0, 0, 0));
        send_word(OP_PIXEL, pack_word(0, 0, 255, 0, 255));
        send_word(OP_PIXEL, pack_word(0, 0, 0, 255, 0));
        send_word(OP_PIXEL, pack_word(0, 0, 255, 255, 255));

        // ramp length zero taken as one, reversed segment
        wait_idle();
        configure(32768, 0);
        send_word(OP_CLEAR, pack_word(0, 0, 0, 0, 0));
        send_word(OP_APPEND, pack_word(Q16_ONE, Q16_ONE, 0, 0, 0));
        send_word(OP_APPEND, pack_word(0, 32768, 0, 0, 0));
        send_word(OP_PIXEL, pack_word(0, 0, 1, 2, 3));

        // ramp length above the maximum, extrapolation below the segment
        wait_idle();
        configure(Q16_ONE, 8191);
        send_word(OP_CLEAR, pack_word(0, 0, 0, 0, 0));
        send_word(OP_APPEND, pack_word(20000, Q16_ONE, 0, 0, 0));
        send_word(OP_APPEND, pack_word(40000, 0, 0, 0, 0));
        send_word(OP_PIXEL, pack_word(0, 0, 128, 64, 32));

        // zero gain, then the ramp shortened below the current position
        wait_idle();
        configure(0, 8);
        repeat (4) send_word(OP_PIXEL, noise_word());
        wait_idle();
        configure(Q16_ONE, 3);
        send_word(OP_PIXEL, noise_word());

        while (items_sent < ITEM_TARGET) begin
            if (items_sent > ITEM_TARGET * 5 / 6) calm = 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 4))
                    0:       new_gain = 17'd0;
                    1:       new_gain = 17'd65536;
                    2:       new_gain = 17'h1FFFF;
                    default: new_gain = $urandom_range(0, Q16_ONE);
                endcase
                case ($urandom_range(0, 7))
                    0:       new_count = 0;
                    1:       new_count = MAX_PIXELS;
                    2:       new_count = 8191;
                    3:       new_count = 1;
                    default: new_count = $urandom_range(2, 32);
                endcase
                wait_idle();
                configure(new_gain, new_count);
            end
            if (!hold_done && items_sent > 300) begin
                // output held off while the input keeps coming
                hold_done    = 1'b1;
                hold_off_req = 1'b1;
                send_ramp();
                send_ramp();
            end else if ($urandom_range(0, 9) < 7) begin
                send_ramp();
            end else begin
                repeat ($urandom_range(1, 12)) send_word($urandom_range(0, 3), noise_word());
            end
        end

        wait_idle();
        if (sb.pending() != 0) begin
            $error("%0d pixel words never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("piecewise_linear_opacity_ramp_top verification clean");
        end else begin
            $display("piecewise_linear_opacity_ramp_top verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/plor_pkg.sv
src/plor_div.sv
src/piecewise_linear_opacity_ramp_top.sv
test/piecewise_linear_opacity_ramp_top_tb.sv
